### hdl/mdcf_pkg.sv
// Package for the motor driver command framer: codes, constants, stage types, helpers.
`timescale 1ns / 1ps
package mdcf_pkg;

    localparam logic [3:0] ACT_RESET     = 4'd0;
    localparam logic [3:0] ACT_MODE      = 4'd1;
    localparam logic [3:0] ACT_OPENLOOP  = 4'd2;
    localparam logic [3:0] ACT_CUR       = 4'd3;
    localparam logic [3:0] ACT_VEL       = 4'd4;
    localparam logic [3:0] ACT_POS       = 4'd5;
    localparam logic [3:0] ACT_VEL_POS   = 4'd6;
    localparam logic [3:0] ACT_CUR_VEL   = 4'd7;
    localparam logic [3:0] ACT_CUR_POS   = 4'd8;
    localparam logic [3:0] ACT_CUR_VEL_POS = 4'd9;
    localparam logic [3:0] ACT_CONFIG    = 4'd10;
    localparam logic [3:0] ACT_ONLINE    = 4'd15;

    localparam logic [7:0]         FILL_BYTE = 8'h55;
    localparam logic [63:0]        FILL_WORD = {8{FILL_BYTE}};
    localparam logic signed [15:0] PWM_MAX   = 16'sd5000;
    localparam logic signed [15:0] PWM_MIN   = -16'sd5000;

    typedef struct packed {
        logic [3:0]  action;
        logic [10:0] frame_id;
        logic [7:0]  mode_byte;
        logic [15:0] pwm;
        logic [15:0] cur;
        logic [15:0] vel;
        logic [31:0] pos;
        logic [7:0]  period;
        logic        limit_en;
    } dec_t;

    typedef struct packed {
        logic [3:0]  action;
        logic [10:0] frame_id;
        logic [7:0]  mode_byte;
        logic [15:0] pwm;
        logic [15:0] pwm_abs;
        logic [15:0] cur;
        logic [15:0] cur_abs;
        logic [15:0] vel;
        logic [15:0] vel_abs;
        logic [31:0] pos;
        logic [7:0]  period;
        logic        limit_en;
    } opnd_t;

    // 16-bit absolute value; the most negative value wraps to itself
    function automatic logic [15:0] abs16(input logic [15:0] v);
        logic [15:0] r;
        r = v[15] ? (16'd0 - v) : v;
        return r;
    endfunction

endpackage

### hdl/mdcf_decode.sv
// Stage 1: address and code check, frame ID, PWM clamp, limit flag.
`timescale 1ns / 1ps
module mdcf_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [3:0]           action,
    input  logic [7:0]           group,
    input  logic [7:0]           node_number,
    input  logic [7:0]           mode_byte,
    input  logic signed [15:0]   pwm_limit,
    input  logic signed [15:0]   current_value,
    input  logic signed [15:0]   velocity_value,
    input  logic signed [31:0]   position_value,
    input  logic [7:0]           feedback_period,
    input  logic [7:0]           limit_switch_enable,
    output logic                 out_valid,
    input  logic                 out_ready,
    output mdcf_pkg::dec_t       out_data
);

    logic           valid_reg;
    logic           valid_next;
    mdcf_pkg::dec_t data_reg;
    mdcf_pkg::dec_t data_next;
    logic           addr_ok;
    logic           code_ok;
    logic           advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        addr_ok = (group[7:3] == 5'd0) && (node_number[7:4] == 4'd0);
        code_ok = (action <= mdcf_pkg::ACT_CONFIG) || (action == mdcf_pkg::ACT_ONLINE);
        valid_next = in_valid && addr_ok && code_ok;

        data_next.action    = action;
        data_next.frame_id  = {group[2:0], node_number[3:0], action};
        data_next.mode_byte = mode_byte;
        priority if (pwm_limit > mdcf_pkg::PWM_MAX) begin
            data_next.pwm = mdcf_pkg::PWM_MAX;
        end else if (pwm_limit < mdcf_pkg::PWM_MIN) begin
            data_next.pwm = mdcf_pkg::PWM_MIN;
        end else begin
            data_next.pwm = pwm_limit;
        end
        data_next.cur      = current_value;
        data_next.vel      = velocity_value;
        data_next.pos      = position_value;
        data_next.period   = feedback_period;
        data_next.limit_en = (limit_switch_enable == 8'd1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/mdcf_operand.sv
// Stage 2: absolute values of PWM, current and velocity.
`timescale 1ns / 1ps
module mdcf_operand (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mdcf_pkg::dec_t  in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output mdcf_pkg::opnd_t out_data
);

    logic            valid_reg;
    mdcf_pkg::opnd_t data_reg;
    mdcf_pkg::opnd_t data_next;
    logic            advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        data_next.action    = in_data.action;
        data_next.frame_id  = in_data.frame_id;
        data_next.mode_byte = in_data.mode_byte;
        data_next.pwm       = in_data.pwm;
        data_next.pwm_abs   = mdcf_pkg::abs16(in_data.pwm);
        data_next.cur       = in_data.cur;
        data_next.cur_abs   = mdcf_pkg::abs16(in_data.cur);
        data_next.vel       = in_data.vel;
        data_next.vel_abs   = mdcf_pkg::abs16(in_data.vel);
        data_next.pos       = in_data.pos;
        data_next.period    = in_data.period;
        data_next.limit_en  = in_data.limit_en;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

### hdl/mdcf_pack.sv
// Stage 3: payload byte assembly per command into the output register.
`timescale 1ns / 1ps
module mdcf_pack (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  mdcf_pkg::opnd_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [10:0]     frame_id,
    output logic [63:0]     payload
);

    logic        valid_reg;
    logic [10:0] id_reg;
    logic [63:0] payload_reg;
    logic [63:0] payload_next;
    logic        advance;

    assign advance  = !valid_reg || out_ready;
    assign in_ready = advance;

    always_comb begin
        payload_next = mdcf_pkg::FILL_WORD;
        unique case (in_data.action)
            mdcf_pkg::ACT_MODE: begin
                payload_next[63:56] = in_data.mode_byte;
            end
            mdcf_pkg::ACT_OPENLOOP: begin
                payload_next[63:48] = in_data.pwm;
            end
            mdcf_pkg::ACT_CUR: begin
                payload_next[63:48] = in_data.pwm_abs;
                payload_next[47:32] = in_data.cur;
            end
            mdcf_pkg::ACT_VEL: begin
                payload_next[63:48] = in_data.pwm_abs;
                payload_next[47:32] = in_data.vel;
            end
            mdcf_pkg::ACT_POS: begin
                payload_next[63:48] = in_data.pwm_abs;
                payload_next[31:0]  = in_data.pos;
            end
            mdcf_pkg::ACT_VEL_POS: begin
                payload_next[63:48] = in_data.pwm_abs;
                payload_next[47:32] = in_data.vel_abs;
                payload_next[31:0]  = in_data.pos;
            end
            mdcf_pkg::ACT_CUR_VEL: begin
                payload_next[63:48] = in_data.cur_abs;
                payload_next[47:32] = in_data.vel;
            end
            mdcf_pkg::ACT_CUR_POS: begin
                payload_next[63:48] = in_data.cur_abs;
                payload_next[31:0]  = in_data.pos;
            end
            mdcf_pkg::ACT_CUR_VEL_POS: begin
                payload_next[63:48] = in_data.cur_abs;
                payload_next[47:32] = in_data.vel_abs;
                payload_next[31:0]  = in_data.pos;
            end
            mdcf_pkg::ACT_CONFIG: begin
                payload_next[63:56] = in_data.period;
                payload_next[55:48] = {7'd0, in_data.limit_en};
            end
            default: begin
                payload_next = mdcf_pkg::FILL_WORD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (advance) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            id_reg      <= in_data.frame_id;
            payload_reg <= payload_next;
        end
    end

    assign out_valid = valid_reg;
    assign frame_id  = id_reg;
    assign payload   = payload_reg;

endmodule

### hdl/motor_driver_command_framer_top.sv
// Top level of the motor driver command framer.
`timescale 1ns / 1ps
// Takes one command request per cycle while not stalled and returns one 8-byte CAN
// data frame (11-bit ID plus payload, byte 0 in bits 63..56) through three
// register stages: decode/clamp, absolute values, byte packing. Requests with
// group above 7, node above 15 or an unused code (11..14) produce no frame.
// Back-pressure on m_ready stalls the stages in place; empty stages keep
// accepting, so throughput is one transfer per cycle.
module motor_driver_command_framer_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [3:0]         s_action,
    input  logic [7:0]         s_group,
    input  logic [7:0]         s_node_number,
    input  logic [7:0]         s_mode_byte,
    input  logic signed [15:0] s_pwm_limit,
    input  logic signed [15:0] s_current_value,
    input  logic signed [15:0] s_velocity_value,
    input  logic signed [31:0] s_position_value,
    input  logic [7:0]         s_feedback_period,
    input  logic [7:0]         s_limit_switch_enable,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [10:0]        m_frame_id,
    output logic [63:0]        m_payload
);

    logic            dec_valid;
    logic            dec_ready;
    mdcf_pkg::dec_t  dec_data;
    logic            opnd_valid;
    logic            opnd_ready;
    mdcf_pkg::opnd_t opnd_data;

    mdcf_decode u_decode (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .in_valid            (s_valid),
        .in_ready            (s_ready),
        .action              (s_action),
        .group               (s_group),
        .node_number         (s_node_number),
        .mode_byte           (s_mode_byte),
        .pwm_limit           (s_pwm_limit),
        .current_value       (s_current_value),
        .velocity_value      (s_velocity_value),
        .position_value      (s_position_value),
        .feedback_period     (s_feedback_period),
        .limit_switch_enable (s_limit_switch_enable),
        .out_valid           (dec_valid),
        .out_ready           (dec_ready),
        .out_data            (dec_data)
    );

    mdcf_operand u_operand (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dec_valid),
        .in_ready  (dec_ready),
        .in_data   (dec_data),
        .out_valid (opnd_valid),
        .out_ready (opnd_ready),
        .out_data  (opnd_data)
    );

    mdcf_pack u_pack (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (opnd_valid),
        .in_ready  (opnd_ready),
        .in_data   (opnd_data),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .frame_id  (m_frame_id),
        .payload   (m_payload)
    );

endmodule

### hdl/mdcf_checker.sv
// Port-level checks for the motor driver command framer, bound to the top level.
`timescale 1ns / 1ps
module mdcf_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input logic [10:0]        m_frame_id,
    input logic [63:0]        m_payload
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_frame_id) && $stable(m_payload))
        else $error("result changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_code_used: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_frame_id[3:0] <= mdcf_pkg::ACT_CONFIG)
                 || (m_frame_id[3:0] == mdcf_pkg::ACT_ONLINE))
        else $error("frame sent for unused command code");

    a_mode_fill: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_id[3:0] == mdcf_pkg::ACT_MODE)
        |-> m_payload[55:0] == mdcf_pkg::FILL_WORD[55:0])
        else $error("mode frame filler bytes wrong");

    a_pwm_clamped: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_frame_id[3:0] == mdcf_pkg::ACT_OPENLOOP)
        |-> ($signed(m_payload[63:48]) <= mdcf_pkg::PWM_MAX)
         && ($signed(m_payload[63:48]) >= mdcf_pkg::PWM_MIN))
        else $error("open loop PWM outside clamp range");

endmodule

bind motor_driver_command_framer_top mdcf_checker u_mdcf_checker (.*);
